/* hw/rtl/ksd_pkg.sv */
// Package for the set-1 keyboard scan-code decoder.
// Holds the prefix and key constants, the decode result type and the
// letter-row lookup. No dependencies.
package ksd_pkg;

  localparam logic [7:0] PFX_EXT     = 8'he0;
  localparam logic [7:0] PFX_PAUSE   = 8'he1;
  localparam logic [7:0] PAUSE_HEAD  = 8'h9d;
  localparam logic [7:0] PAUSE_TAIL  = 8'hc5;
  localparam logic [6:0] LSHIFT_CODE = 7'h2a;
  localparam logic [6:0] RSHIFT_CODE = 7'h36;
  localparam logic [6:0] ESC_CODE    = 7'h01;
  localparam logic [6:0] F10_CODE    = 7'h44;

  typedef struct packed {
    logic       hit;
    logic [6:0] key_code;
    logic       key_released;
    logic       quit_request;
  } ksd_result_t;

  // Scan code to lower-case ASCII for the three letter rows; zero if none.
  function automatic logic [6:0] letter_of(input logic [6:0] c);
    logic [6:0] a;
    a = 7'h00;
    unique case (c)
      7'h10: a = 7'h71; // q
      7'h11: a = 7'h77; // w
      7'h12: a = 7'h65; // e
      7'h13: a = 7'h72; // r
      7'h14: a = 7'h74; // t
      7'h15: a = 7'h79; // y
      7'h16: a = 7'h75; // u
      7'h17: a = 7'h69; // i
      7'h18: a = 7'h6f; // o
      7'h19: a = 7'h70; // p
      7'h1e: a = 7'h61; // a
      7'h1f: a = 7'h73; // s
      7'h20: a = 7'h64; // d
      7'h21: a = 7'h66; // f
      7'h22: a = 7'h67; // g
      7'h23: a = 7'h68; // h
      7'h24: a = 7'h6a; // j
      7'h25: a = 7'h6b; // k
      7'h26: a = 7'h6c; // l
      7'h2c: a = 7'h7a; // z
      7'h2d: a = 7'h78; // x
      7'h2e: a = 7'h63; // c
      7'h2f: a = 7'h76; // v
      7'h30: a = 7'h62; // b
      7'h31: a = 7'h6e; // n
      7'h32: a = 7'h6d; // m
      default: a = 7'h00;
    endcase
    return a;
  endfunction

  function automatic logic is_listed(input logic [6:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07, 7'h0c, 7'h0d, 7'h1c, 7'h39, 7'h36,
      7'h48, 7'h50, 7'h4b, 7'h4d, 7'h0f, 7'h1d, 7'h38, 7'h33, 7'h34, 7'h1b,
      7'h3f: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/keyboard_scancode_decoder_core.sv */
// Top level of the set-1 keyboard scan-code decoder: input register,
// decode, result register. Depends on ksd_pkg and ksd_decode.
//
// Usage:
//   Input channel in_valid/in_ready carries one raw scan byte per word.
//   Result channel out_valid/out_ready carries key_code, key_released and
//   quit_request; a byte yields zero or one result word. Prefix bytes,
//   pause sequences, extended shifts and unmapped keys give no word.
//   An accepted byte waits in the input register, is decoded, and its
//   word is loaded into the result register. Throughput: one byte per
//   cycle when not stalled, set by the single decode stage between them.
//   The prior byte register follows every accepted byte, dropped or not.
//   Reset (rst_n low, synchronous) empties both stages and clears the
//   prior byte to zero.
//   When the receiver stalls, the result register holds its word, the
//   input register holds one more byte, and in_ready falls only while
//   that held byte would produce a result with nowhere to go.
module keyboard_scancode_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_key_code,
  output logic       out_key_released,
  output logic       out_quit_request
);

  logic                 s1_valid_r, s1_valid_nxt;
  logic [7:0]           s1_byte_r;
  logic [7:0]           s1_prev_r;
  logic [7:0]           prior_r;
  logic                 out_valid_r, out_valid_nxt;
  ksd_pkg::ksd_result_t out_word_r;
  ksd_pkg::ksd_result_t dec;
  logic                 out_free;
  logic                 s1_go;
  logic                 in_take;
  logic                 out_load;

  ksd_decode u_decode (
    .scan_byte  (s1_byte_r),
    .prior_byte (s1_prev_r),
    .result     (dec)
  );

  always_comb begin
    out_free      = !out_valid_r || out_ready;
    s1_go         = !dec.hit || out_free;
    in_ready      = !s1_valid_r || s1_go;
    in_take       = in_valid && in_ready;
    out_load      = s1_valid_r && dec.hit && out_free;
    s1_valid_nxt  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prior_r     <= 8'h00;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_take) begin
        prior_r <= in_scan_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_scan_byte;
      s1_prev_r <= prior_r;
    end
    if (out_load) begin
      out_word_r <= dec;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_key_code     = out_word_r.key_code;
  assign out_key_released = out_word_r.key_released;
  assign out_quit_request = out_word_r.quit_request;

`ifndef SYNTHESIS
  a_quit_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_quit_request |-> out_key_code == 7'h00)
    else $error("quit word with non-zero key code");

  a_prior_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> prior_r == $past(in_scan_byte) && s1_valid_r)
    else $error("prior byte or input stage not updated on accept");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && dec.hit && out_valid_r && !out_ready |=>
      s1_valid_r && $stable(s1_byte_r) && $stable(s1_prev_r))
    else $error("input stage lost a pending word during stall");

  a_no_hit_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !dec.hit && out_valid_r && !out_ready |=> $stable(out_word_r))
    else $error("result register changed without a decoded word");
`endif

endmodule

/* hw/rtl/ksd_decode.sv */
// Combinational decode of one scan byte given the byte received before it.
// Depends on ksd_pkg.
module ksd_decode (
  input  logic [7:0]          scan_byte,
  input  logic [7:0]          prior_byte,
  output ksd_pkg::ksd_result_t result
);

  logic [7:0] k;
  logic [6:0] c;
  logic [6:0] letter;
  logic       is_shift;
  logic       drop;

  always_comb begin
    is_shift = (scan_byte[6:0] == ksd_pkg::LSHIFT_CODE) ||
               (scan_byte[6:0] == ksd_pkg::RSHIFT_CODE);
    k        = is_shift ? {scan_byte[7], ksd_pkg::RSHIFT_CODE} : scan_byte;
    c        = k[6:0];
    letter   = ksd_pkg::letter_of(c);
    drop     = (is_shift && prior_byte == ksd_pkg::PFX_EXT) ||
               (k == ksd_pkg::PFX_EXT) ||
               (prior_byte == ksd_pkg::PFX_PAUSE) ||
               (k == ksd_pkg::PAUSE_TAIL && prior_byte == ksd_pkg::PAUSE_HEAD);

    result.key_released = k[7];
    result.key_code     = 7'h00;
    result.quit_request = 1'b0;
    result.hit          = 1'b0;
    if (!drop) begin
      if (ksd_pkg::is_listed(c)) begin
        result.key_code = c;
        result.hit      = 1'b1;
      end else if (c == ksd_pkg::ESC_CODE || c == ksd_pkg::F10_CODE) begin
        result.quit_request = 1'b1;
        result.hit          = 1'b1;
      end else if (letter != 7'h00) begin
        result.key_code = letter;
        result.hit      = 1'b1;
      end
    end
  end

endmodule
